/* rtl/audio_matrix_mixer_top_defines.svh */
// assertion macros shared by the mixer rtl
`ifndef AUDIO_MATRIX_MIXER_TOP_DEFINES_SVH
`define AUDIO_MATRIX_MIXER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with reset masked
`define AMM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define AMM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/amm_pkg.sv */
// shared types, constants and helpers of the matrix mixer
package amm_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int CH_W        = 4;
  localparam int CNT_W       = 5;
  localparam int SMP_W       = 24;
  localparam int GAIN_W      = 18;
  localparam int PROD_W      = SMP_W + GAIN_W;
  localparam int ACC_W       = 48;
  localparam int SUM_W       = ACC_W + 1;
  localparam int TBL_DEPTH   = MAX_INPUTS * MAX_OUTPUTS;
  localparam int TBL_AW      = 2 * CH_W;
  localparam int RND_SH      = 14;
  localparam int CFG_IDX_W   = 1;

  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_SET_GAIN = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  localparam logic RK_SAMPLE = 1'b0;
  localparam logic RK_ACK    = 1'b1;

  localparam logic STS_OK    = 1'b0;
  localparam logic STS_RANGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 1'd1;

  localparam logic [CNT_W-1:0] IN_CAP  = CNT_W'(MAX_INPUTS);
  localparam logic [CNT_W-1:0] OUT_CAP = CNT_W'(MAX_OUTPUTS);

  typedef struct packed {
    logic             load;
    logic             gain_wr;
    logic             tbl_clr;
    logic             mac_rd;
    logic             emit;
    logic             ack;
    logic             ack_status;
    logic             acc_clr;
    logic [CH_W-1:0]  idx;
    logic             idx_last;
  } amm_cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             frame_end;
    logic             in_active;
    logic             gain_ok;
    logic [CNT_W-1:0] n_out;
    logic             pipe_busy;
    logic             out_free;
  } amm_sts_t;

  function automatic logic [CNT_W-1:0] cap_count(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
    cap_count = (v > cap) ? cap : v;
  endfunction

endpackage

/* rtl/amm_ram.sv */
// generic single-port-write ram with registered read
module amm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/amm_dp.sv */
// datapath: config, gain table, mac pipeline, accumulators, output register
`include "audio_matrix_mixer_top_defines.svh"
module amm_dp import amm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CNT_W-1:0]            cfg_data,
  input  logic [1:0]                  in_kind,
  input  logic [CH_W-1:0]             in_channel,
  input  logic [CH_W-1:0]             in_out_channel,
  input  logic signed [SMP_W-1:0]     in_sample_value,
  input  logic signed [GAIN_W-1:0]    in_gain_value,
  input  logic                        in_frame_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_result_kind,
  output logic [CH_W-1:0]             out_index,
  output logic signed [SMP_W-1:0]     out_sample,
  output logic                        out_last,
  output logic                        out_status,
  input  amm_cmd_t                    cmd,
  output amm_sts_t                    sts
);

  logic [CNT_W-1:0]          num_in_r, num_in_nxt;
  logic [CNT_W-1:0]          num_out_r, num_out_nxt;
  logic [CNT_W-1:0]          ni, no, ni_nxt, no_nxt;
  logic [TBL_DEPTH-1:0]      valid_r, valid_nxt;

  logic [1:0]                kind_r;
  logic [CH_W-1:0]           ic_r, oc_r;
  logic signed [SMP_W-1:0]   smp_r;
  logic signed [GAIN_W-1:0]  gain_in_r;
  logic                      fend_r;

  logic [TBL_AW-1:0]         waddr, raddr;
  logic [GAIN_W-1:0]         ram_rdata;
  logic                      gvalid_r;
  logic                      s1_v_r, s2_v_r;
  logic [CH_W-1:0]           idx1_r, idx2_r;
  logic signed [GAIN_W-1:0]  gain_eff;
  logic signed [PROD_W-1:0]  prod_nxt, prod_r;

  logic signed [ACC_W-1:0]   acc_r [MAX_OUTPUTS];
  logic signed [SUM_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   acc_sat;
  logic signed [SUM_W-1:0]   rnd;
  logic signed [SMP_W-1:0]   smp_out;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_rk_r, out_last_r, out_status_r;
  logic [CH_W-1:0]           out_idx_r;
  logic signed [SMP_W-1:0]   out_smp_r;

  // configuration
  always_comb begin
    num_in_nxt  = num_in_r;
    num_out_nxt = num_out_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_INPUTS:  num_in_nxt  = cfg_data;
        REG_NUM_OUTPUTS: num_out_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign ni     = cap_count(num_in_r, IN_CAP);
  assign no     = cap_count(num_out_r, OUT_CAP);
  assign ni_nxt = cap_count(num_in_nxt, IN_CAP);
  assign no_nxt = cap_count(num_out_nxt, OUT_CAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_in_r  <= '0;
      num_out_r <= '0;
    end else begin
      num_in_r  <= num_in_nxt;
      num_out_r <= num_out_nxt;
    end
  end

  // per-entry valid bits stand in for the zeroed table
  always_comb begin
    logic [TBL_AW-1:0] a_v;
    a_v       = '0;
    valid_nxt = valid_r;
    if (cmd.tbl_clr) begin
      valid_nxt = '0;
    end else if (cmd.gain_wr) begin
      valid_nxt[waddr] = 1'b1;
    end
    if (cfg_wr_en) begin
      for (int a = 0; a < TBL_DEPTH; a++) begin
        a_v = TBL_AW'(a);
        if (!(({1'b0, a_v[TBL_AW-1:CH_W]} < ni_nxt) &&
              ({1'b0, a_v[CH_W-1:0]} < no_nxt))) begin
          valid_nxt[a_v] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // request fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      ic_r      <= in_channel;
      oc_r      <= in_out_channel;
      smp_r     <= in_sample_value;
      gain_in_r <= in_gain_value;
      fend_r    <= in_frame_end;
    end
  end

  // gain table
  assign waddr = {ic_r, oc_r};
  assign raddr = {ic_r, cmd.idx};

  amm_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (TBL_DEPTH)
  ) u_gain_ram (
    .clk   (clk),
    .we    (cmd.gain_wr),
    .waddr (waddr),
    .wdata (gain_in_r),
    .re    (cmd.mac_rd),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // mac pipeline
  always_ff @(posedge clk) begin
    if (cmd.mac_rd) begin
      gvalid_r <= valid_r[raddr];
    end
    idx1_r <= cmd.idx;
    idx2_r <= idx1_r;
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.mac_rd;
      s2_v_r <= s1_v_r;
    end
  end

  assign gain_eff = gvalid_r ? $signed(ram_rdata) : '0;
  assign prod_nxt = PROD_W'(smp_r) * PROD_W'(gain_eff);

  assign acc_sum = SUM_W'(acc_r[idx2_r]) + SUM_W'(prod_r);

  always_comb begin
    if (acc_sum[SUM_W-1] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int o = 0; o < MAX_OUTPUTS; o++) begin
        acc_r[o] <= '0;
      end
    end else if (cmd.acc_clr) begin
      for (int o = 0; o < MAX_OUTPUTS; o++) begin
        acc_r[o] <= '0;
      end
    end else if (s2_v_r) begin
      acc_r[idx2_r] <= acc_sat;
    end
  end

  // round half up and saturate to sample width
  assign rnd = SUM_W'(acc_r[cmd.idx]) + (SUM_W'(1) <<< (RND_SH - 1));

  always_comb begin
    if (rnd[SUM_W-1:SMP_W+RND_SH-1] != {(SUM_W-SMP_W-RND_SH+1){rnd[SUM_W-1]}}) begin
      smp_out = rnd[SUM_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end else begin
      smp_out = rnd[SMP_W+RND_SH-1:RND_SH];
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit || cmd.ack) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rk_r     <= RK_SAMPLE;
      out_idx_r    <= cmd.idx;
      out_smp_r    <= smp_out;
      out_last_r   <= cmd.idx_last;
      out_status_r <= STS_OK;
    end else if (cmd.ack) begin
      out_rk_r     <= RK_ACK;
      out_idx_r    <= '0;
      out_smp_r    <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.ack_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_rk_r;
  assign out_index       = out_idx_r;
  assign out_sample      = out_smp_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;

  // status
  assign sts.kind      = kind_r;
  assign sts.frame_end = fend_r;
  assign sts.in_active = ({1'b0, ic_r} < ni);
  assign sts.gain_ok   = ({1'b0, ic_r} < ni) && ({1'b0, oc_r} < no);
  assign sts.n_out     = no;
  assign sts.pipe_busy = s1_v_r || s2_v_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  `AMM_ASSERT_IMP(a_acc_no_collide, s2_v_r, !cmd.emit && !cmd.acc_clr,
                  "accumulator update collides with readout or clear")
  `AMM_ASSERT_IMP(a_ram_quiet_on_wr, cmd.gain_wr, !s1_v_r && !cmd.mac_rd,
                  "gain write while mac pipeline reads the table")
  `AMM_ASSERT_IMP(a_wr_in_range, cmd.gain_wr, sts.gain_ok,
                  "gain write outside the active area")

endmodule

/* rtl/amm_ctrl.sv */
// controller: sequences decode, mac sweep, drain, readout and acknowledge
`include "audio_matrix_mixer_top_defines.svh"
module amm_ctrl import amm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output amm_cmd_t cmd,
  input  amm_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT,
    ST_ACK
  } state_t;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.idx      = cnt_r;
    cmd.idx_last = ({1'b0, cnt_r} == (sts.n_out - CNT_W'(1)));
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cnt_nxt = '0;
        case (sts.kind)
          KIND_SET_GAIN: begin
            cmd.gain_wr = sts.gain_ok;
            state_nxt   = ST_ACK;
          end
          KIND_CLEAR: begin
            cmd.tbl_clr = 1'b1;
            state_nxt   = ST_ACK;
          end
          KIND_SAMPLE: begin
            if (sts.in_active && sts.n_out != '0) begin
              state_nxt = ST_MAC;
            end else if (sts.frame_end && sts.n_out != '0) begin
              state_nxt = ST_EMIT;
            end else begin
              cmd.acc_clr = sts.frame_end;
              state_nxt   = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MAC: begin
        cmd.mac_rd = 1'b1;
        cnt_nxt    = cnt_r + CH_W'(1);
        if (cmd.idx_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = sts.frame_end ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cnt_nxt  = cnt_r + CH_W'(1);
          if (cmd.idx_last) begin
            cmd.acc_clr = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.ack        = 1'b1;
          cmd.ack_status = (sts.kind == KIND_SET_GAIN && !sts.gain_ok) ? STS_RANGE : STS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  `AMM_ASSERT_IMP(a_result_slot_free, cmd.emit || cmd.ack, sts.out_free,
                  "result loaded while output register still occupied")
  `AMM_ASSERT_IMP(a_mac_idx_range, cmd.mac_rd, {1'b0, cmd.idx} < sts.n_out,
                  "mac sweep beyond active outputs")
  `AMM_ASSERT_IMP(a_clr_on_frame_end, cmd.acc_clr,
                  sts.frame_end && sts.kind == KIND_SAMPLE,
                  "accumulators cleared without a frame end")

endmodule

/* rtl/audio_matrix_mixer_top.sv */
// top level of the audio matrix mixer
//
// Input channel (in_valid/in_ready) takes one request: a sample for one input
// column, a gain write into the 16x16 table, or a table clear. The result
// channel (out_valid/out_ready) returns acknowledges for commands and, on a
// frame end, one saturated Q1.23 sample per active output, the final one with
// out_last set. cfg_wr_en/cfg_index/cfg_data set the active input and output
// counts; a change zeroes gains outside the new active area.
// Timing: a request is decoded in the cycle after acceptance. A sample on an
// active input sweeps the outputs with one multiply-accumulate per cycle
// through a table read, multiply and accumulate pipeline. A frame end then
// emits one result per cycle while the receiver takes them. An acknowledge
// is loaded into the output register from the acknowledge state, which
// follows decode. The single shared multiplier serves the active outputs
// one after another; a new request is taken only once the previous one has
// loaded its last result.
// Reset clears the counts, the table (through per-entry valid bits) and the
// accumulators at once; no clearing pass. A stalled receiver holds the
// output register and pauses the readout; nothing is dropped.
module audio_matrix_mixer_top import amm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_kind,
  input  logic [CH_W-1:0]          in_channel,
  input  logic [CH_W-1:0]          in_out_channel,
  input  logic signed [SMP_W-1:0]  in_sample_value,
  input  logic signed [GAIN_W-1:0] in_gain_value,
  input  logic                     in_frame_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_result_kind,
  output logic [CH_W-1:0]          out_index,
  output logic signed [SMP_W-1:0]  out_sample,
  output logic                     out_last,
  output logic                     out_status
);

  amm_cmd_t cmd;
  amm_sts_t sts;

  amm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  amm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_channel      (in_channel),
    .in_out_channel  (in_out_channel),
    .in_sample_value (in_sample_value),
    .in_gain_value   (in_gain_value),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_index       (out_index),
    .out_sample      (out_sample),
    .out_last        (out_last),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
